@@ design/ahfe_pkg.sv @@
// ----------------------------------------------------------------------------
// ahfe_pkg
// Shared types, constants and character helpers for the ASCII hex frame
// encoder.
// ----------------------------------------------------------------------------
package ahfe_pkg;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [6:0] FRAME_MAX = 7'd85;
  localparam logic [6:0] FRAME_MIN = 7'd2;

  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_1 = 8'h31;
  localparam logic [7:0] CHAR_2 = 8'h32;
  localparam logic [7:0] CHAR_8 = 8'h38;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_F = 8'h46;

  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_ACK  = 1'b1;

  // step positions within a data command, header included
  localparam logic [3:0] POS_HDR0 = 4'd0;
  localparam logic [3:0] POS_HDR1 = 4'd1;
  localparam logic [3:0] POS_LENH = 4'd2;
  localparam logic [3:0] POS_LENL = 4'd3;
  localparam logic [3:0] POS_W2   = 4'd4;
  localparam logic [3:0] POS_W1   = 4'd5;
  localparam logic [3:0] POS_W0   = 4'd6;
  localparam logic [3:0] POS_CHKH = 4'd7;
  localparam logic [3:0] POS_CHKL = 4'd8;
  localparam logic [3:0] HDR_BYTES = 4'd4;

  localparam logic [2:0] LAST_ACK  = 3'd7;
  localparam logic [2:0] LAST_HDR  = 3'd6;
  localparam logic [2:0] LAST_CHK  = 3'd4;
  localparam logic [2:0] LAST_WORD = 3'd2;

  typedef struct packed {
    logic        is_ack;
    logic        has_hdr;
    logic [7:0]  hdr_len;
    logic [11:0] word;
    logic        has_chk;
    logic [7:0]  chk;
  } cmd_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib <= 4'd9) begin
      ch = CHAR_0 + {4'd0, nib};
    end else begin
      ch = CHAR_A + {4'd0, nib} - 8'd10;
    end
    return ch;
  endfunction

  // "02018001"
  function automatic logic [7:0] ack_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd1:    ch = CHAR_2;
      3'd3:    ch = CHAR_1;
      3'd4:    ch = CHAR_8;
      3'd7:    ch = CHAR_1;
      default: ch = CHAR_0;
    endcase
    return ch;
  endfunction

endpackage

@@ design/ahfe_front.sv @@
// ----------------------------------------------------------------------------
// ahfe_front
// Accepts input words, tracks frame state and turns each word into one
// byte-sequence command for the back end.
// ----------------------------------------------------------------------------
module ahfe_front
  import ahfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_kind,
  input  logic [11:0] in_word,
  input  logic [6:0]  in_len,
  input  logic        q_full,
  output logic        in_ready,
  output logic        push,
  output cmd_t        cmd
);

  logic [6:0] word_index, word_index_next;
  logic [7:0] char_sum, char_sum_next;
  logic [6:0] frame_length, frame_length_next;

  logic       first;
  logic [6:0] len_clamp;
  logic [6:0] len_use;
  logic [6:0] idx_inc;
  logic [7:0] sum_new;
  logic [7:0] d2, d1, d0;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    first = (word_index == 7'd0);
    if (in_len > FRAME_MAX) begin
      len_clamp = FRAME_MAX;
    end else if (in_len < FRAME_MIN) begin
      len_clamp = FRAME_MIN;
    end else begin
      len_clamp = in_len;
    end
    len_use = first ? len_clamp : frame_length;
    d2 = hex_char(in_word[11:8]);
    d1 = hex_char(in_word[7:4]);
    d0 = hex_char(in_word[3:0]);
    sum_new = (first ? 8'd0 : char_sum) + d2 + d1 + d0;
    idx_inc = word_index + 7'd1;

    cmd.is_ack  = (in_kind == REQ_ACK);
    cmd.has_hdr = first;
    cmd.hdr_len = {1'b0, len_clamp} + {len_clamp, 1'b0};
    cmd.word    = in_word;
    cmd.has_chk = (idx_inc >= len_use);
    cmd.chk     = 8'd0 - sum_new;

    word_index_next   = word_index;
    char_sum_next     = char_sum;
    frame_length_next = frame_length;
    if (push && in_kind == REQ_DATA) begin
      frame_length_next = len_use;
      if (cmd.has_chk) begin
        word_index_next = 7'd0;
        char_sum_next   = 8'd0;
      end else begin
        word_index_next = idx_inc;
        char_sum_next   = sum_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index   <= 7'd0;
      char_sum     <= 8'd0;
      frame_length <= 7'd0;
    end else begin
      word_index   <= word_index_next;
      char_sum     <= char_sum_next;
      frame_length <= frame_length_next;
    end
  end

endmodule

@@ design/ahfe_queue.sv @@
// ----------------------------------------------------------------------------
// ahfe_queue
// Small command FIFO between front and back end.
// ----------------------------------------------------------------------------
module ahfe_queue
  import ahfe_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output cmd_t head
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ design/ahfe_back.sv @@
// ----------------------------------------------------------------------------
// ahfe_back
// Steps through one command a byte per cycle, while the output is not stalled, into a registered output word.
// ----------------------------------------------------------------------------
module ahfe_back
  import ahfe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_not_empty,
  input  cmd_t       q_head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_done
);

  logic       busy;
  cmd_t       cur;
  logic [2:0] step;

  logic       advance;
  logic       at_last;
  logic [2:0] last_step;
  logic [3:0] pos;
  logic [7:0] byte_sel;

  always_comb begin
    if (cur.is_ack) begin
      last_step = LAST_ACK;
    end else if (cur.has_hdr) begin
      last_step = LAST_HDR;
    end else if (cur.has_chk) begin
      last_step = LAST_CHK;
    end else begin
      last_step = LAST_WORD;
    end
    at_last = (step == last_step);
    advance = busy && (!out_valid || out_ready);
    pop     = q_not_empty && (!busy || (advance && at_last));

    pos = {1'b0, step} + (cur.has_hdr ? 4'd0 : HDR_BYTES);
    case (pos)
      POS_HDR0: byte_sel = CHAR_0;
      POS_HDR1: byte_sel = CHAR_2;
      POS_LENH: byte_sel = hex_char(cur.hdr_len[7:4]);
      POS_LENL: byte_sel = hex_char(cur.hdr_len[3:0]);
      POS_W2:   byte_sel = hex_char(cur.word[11:8]);
      POS_W1:   byte_sel = hex_char(cur.word[7:4]);
      POS_W0:   byte_sel = hex_char(cur.word[3:0]);
      POS_CHKH: byte_sel = hex_char(cur.chk[7:4]);
      POS_CHKL: byte_sel = hex_char(cur.chk[3:0]);
      default:  byte_sel = CHAR_0;
    endcase
    if (cur.is_ack) begin
      byte_sel = ack_char(step);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
    end
    if (advance) begin
      out_byte <= byte_sel;
      out_last <= at_last;
      out_done <= at_last && !cur.is_ack && cur.has_chk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        step      <= step + 3'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
        step <= 3'd0;
      end else if (advance && at_last) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

@@ design/ascii_hex_frame_encoder.sv @@
// A word's first byte passes through the queue, the back end's command and output
// registers. Throughput: one byte per cycle unless m_tready stalls, set by the
// back end's one-byte output register. A word is 3 digits, plus 4 header bytes
// on a frame's first word, 2 checksum bytes on its last, 8 for an acknowledge.
// Up to QUEUE_DEPTH words are buffered ahead of the back end.
// Reset (rst, synchronous) clears frame state, the queue and the output valid.
// ----------------------------------------------------------------------------
// ascii_hex_frame_encoder
// Encodes 12-bit words into framed ASCII hex with header and checksum.
// ----------------------------------------------------------------------------
module ascii_hex_frame_encoder
  import ahfe_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [11:0] data_word, [18:12] frame_words, rest 0
  input  logic        s_tuser,   // [0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] tx_byte
  output logic        m_tlast,   // last_of_run
  output logic        m_tuser    // [0] frame_done
);

  logic q_full;
  logic q_not_empty;
  logic push;
  logic pop;
  cmd_t cmd;
  cmd_t head;

  ahfe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_word  (s_tdata[11:0]),
    .in_len   (s_tdata[18:12]),
    .q_full   (q_full),
    .in_ready (s_tready),
    .push     (push),
    .cmd      (cmd)
  );

  ahfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  ahfe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (head),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_byte    (m_tdata),
    .out_last    (m_tlast),
    .out_done    (m_tuser)
  );

endmodule

@@ design/ahfe_checker.sv @@
// ----------------------------------------------------------------------------
// ahfe_checker
// Port-level checks on the encoder output stream.
// ----------------------------------------------------------------------------
module ahfe_checker
  import ahfe_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("frame end without end of run");

  a_hex_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata >= CHAR_0 && m_tdata <= CHAR_9) ||
                  (m_tdata >= CHAR_A && m_tdata <= CHAR_F)))
    else $error("non-hex character on output");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) &&
                                 $stable(m_tlast) && $stable(m_tuser)))
    else $error("output word changed under stall");

endmodule

bind ascii_hex_frame_encoder ahfe_checker u_ahfe_checker (.*);
